// ===== hdl/vrs_pkg.sv =====
// ----------------------------------------------------------------------------
// vrs_pkg
// Shared constants and types of the voltage running statistics block.
// ----------------------------------------------------------------------------
package vrs_pkg;

  localparam int COUNT_BITS = 32;
  localparam int CODE_BITS  = 10;
  localparam int SUM_BITS   = COUNT_BITS + CODE_BITS;
  localparam int ADDR_BITS  = 2;
  localparam int DATA_BITS  = 32;

  localparam logic [CODE_BITS-1:0] CODE_FULL = 10'd1023;
  localparam logic [CODE_BITS-1:0] REF_RESET = 10'd500;

  localparam logic [ADDR_BITS-1:0] ADDR_REFERENCE = 2'd0;

  localparam logic [1:0] KIND_SAMPLE = 2'd0;
  localparam logic [1:0] KIND_HOLD   = 2'd1;
  localparam logic [1:0] KIND_RUN    = 2'd2;

  typedef struct packed {
    logic                 hold;
    logic [CODE_BITS-1:0] code;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_port_t;

endpackage

// ===== hdl/vrs_front.sv =====
// ----------------------------------------------------------------------------
// vrs_front
// Accepts input words, tracks the run and hold mode, and queues samples.
// ----------------------------------------------------------------------------
module vrs_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [1:0]                    kind,
  input  logic [vrs_pkg::CODE_BITS-1:0] sample_code,
  input  logic                          queue_full,
  output vrs_pkg::q_port_t              push
);

  logic hold_mode;
  logic accept;

  assign item_stall = queue_full;
  assign accept     = item_valid && !item_stall;

  always_comb begin
    push.valid      = accept && (kind == vrs_pkg::KIND_SAMPLE);
    push.entry.hold = hold_mode;
    push.entry.code = sample_code;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_mode <= 1'b0;
    end else if (accept) begin
      if (kind == vrs_pkg::KIND_HOLD) begin
        hold_mode <= 1'b1;
      end else if (kind == vrs_pkg::KIND_RUN) begin
        hold_mode <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/vrs_queue.sv =====
// ----------------------------------------------------------------------------
// vrs_queue
// Two-entry queue of classified samples between the front and back ends.
// ----------------------------------------------------------------------------
module vrs_queue (
  input  logic             clk,
  input  logic             rst,
  input  vrs_pkg::q_port_t push,
  output logic             full,
  input  logic             pop,
  output vrs_pkg::q_port_t head
);

  vrs_pkg::q_entry_t entries [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        fill;
  logic              do_push;
  logic              do_pop;

  assign full       = (fill == 2'd2);
  assign head.valid = (fill != 2'd0);
  assign head.entry = entries[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 2'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 2'd1;
      end
    end
  end

endmodule

// ===== hdl/vrs_back.sv =====
// ----------------------------------------------------------------------------
// vrs_back
// Updates the statistics, divides for the average and scales to centivolts.
// ----------------------------------------------------------------------------
module vrs_back (
  input  logic                          clk,
  input  logic                          rst,
  input  vrs_pkg::q_port_t              head,
  output logic                          pop,
  input  logic [vrs_pkg::CODE_BITS-1:0] reference_centivolts,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [vrs_pkg::CODE_BITS-1:0] current_cv,
  output logic [vrs_pkg::CODE_BITS-1:0] average_cv,
  output logic [vrs_pkg::CODE_BITS-1:0] maximum_cv,
  output logic [vrs_pkg::CODE_BITS-1:0] minimum_cv,
  output logic                          stats_valid
);

  localparam int CB   = vrs_pkg::COUNT_BITS;
  localparam int W    = vrs_pkg::CODE_BITS;
  localparam int SB   = vrs_pkg::SUM_BITS;
  localparam int PB   = 2 * W;
  localparam logic [3:0] DIV_LAST  = 4'(W - 1);
  localparam logic [2:0] CONV_LAST = 3'd4;

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_CONV, ST_WRITE} state_t;

  state_t          state;
  logic [W-1:0]    current_code;
  logic [W-1:0]    minimum_code;
  logic [W-1:0]    maximum_code;
  logic [CB-1:0]   sample_count;
  logic [SB-1:0]   sample_sum;
  logic            hold_item;
  logic [CB-1:0]   rem;
  logic [W-1:0]    low_bits;
  logic [W-1:0]    quot;
  logic [3:0]      div_step;
  logic [2:0]      conv_step;
  logic [PB-1:0]   prod;
  logic [W-1:0]    cv [4];

  logic [CB-1:0]   sample_count_next;
  logic [SB-1:0]   sample_sum_next;
  logic [W-1:0]    minimum_code_next;
  logic [W-1:0]    maximum_code_next;
  logic [CB:0]     trial;
  logic            trial_ok;
  logic [W-1:0]    conv_code;
  logic [W-1:0]    scaled;

  function automatic logic [W-1:0] div1023(input logic [PB-1:0] p);
    logic [PB:0]   q0;
    logic [PB+W:0] r;
    begin
      q0 = ({1'b0, p} + {11'd0, p[PB-1:W]}) >> W;
      r  = {{W{1'b0}}, 1'b0, p} - (({{W{1'b0}}, q0} << W) - {{W{1'b0}}, q0});
      if (r >= (PB + W + 1)'(vrs_pkg::CODE_FULL)) begin
        q0 = q0 + 1'b1;
      end
      div1023 = q0[W-1:0];
    end
  endfunction

  always_comb begin
    if (sample_count == {CB{1'b1}}) begin
      sample_count_next = {{(CB-1){1'b0}}, 1'b1};
      sample_sum_next   = SB'(head.entry.code);
    end else begin
      sample_count_next = sample_count + 1'b1;
      sample_sum_next   = sample_sum + SB'(head.entry.code);
    end
    minimum_code_next = (head.entry.code < minimum_code) ? head.entry.code : minimum_code;
    maximum_code_next = (head.entry.code > maximum_code) ? head.entry.code : maximum_code;
  end

  assign trial    = {rem, low_bits[W-1]};
  assign trial_ok = (trial >= {1'b0, sample_count});

  always_comb begin
    unique case (conv_step[1:0])
      2'd0:    conv_code = current_code;
      2'd1:    conv_code = quot;
      2'd2:    conv_code = maximum_code;
      default: conv_code = minimum_code;
    endcase
  end

  assign scaled = div1023(prod);
  assign pop    = (state == ST_IDLE) && head.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      current_code <= '0;
      minimum_code <= vrs_pkg::CODE_FULL;
      maximum_code <= '0;
      sample_count <= '0;
      sample_sum   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != ST_WRITE)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (head.valid) begin
            current_code <= head.entry.code;
            hold_item    <= head.entry.hold;
            conv_step    <= '0;
            div_step     <= '0;
            if (head.entry.hold) begin
              minimum_code <= vrs_pkg::CODE_FULL;
              maximum_code <= '0;
              sample_count <= '0;
              sample_sum   <= '0;
              state        <= ST_CONV;
            end else begin
              minimum_code <= minimum_code_next;
              maximum_code <= maximum_code_next;
              sample_count <= sample_count_next;
              sample_sum   <= sample_sum_next;
              rem          <= sample_sum_next[SB-1:W];
              low_bits     <= sample_sum_next[W-1:0];
              state        <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          if (trial_ok) begin
            rem <= trial[CB-1:0] - sample_count;
          end else begin
            rem <= trial[CB-1:0];
          end
          quot     <= {quot[W-2:0], trial_ok};
          low_bits <= {low_bits[W-2:0], 1'b0};
          div_step <= div_step + 4'd1;
          if (div_step == DIV_LAST) begin
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          prod <= PB'(conv_code) * PB'(reference_centivolts);
          if (conv_step != 3'd0) begin
            cv[conv_step[1:0] - 2'd1] <= scaled;
          end
          conv_step <= conv_step + 3'd1;
          if (conv_step == CONV_LAST) begin
            state <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          if (!result_valid || !result_stall) begin
            current_cv   <= cv[0];
            average_cv   <= hold_item ? '0 : cv[1];
            maximum_cv   <= hold_item ? '0 : cv[2];
            minimum_cv   <= hold_item ? '0 : cv[3];
            stats_valid  <= !hold_item;
            result_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== hdl/voltage_running_statistics.sv =====
// ----------------------------------------------------------------------------
// voltage_running_statistics
// Running current, average, maximum and minimum of converter samples.
// ----------------------------------------------------------------------------
// Key words are taken by the front end and give no result; samples pass
// through a two-entry queue to the back end, which for a run-mode sample
// updates the statistics, runs the bit-serial divider for the average, passes
// the values through the shared scaling multiplier and loads the output
// register; a hold-mode sample clears the statistics and skips the divider.
// The output register may wait to be taken. The reference register sits at
// byte address 0 of the configuration port and resets to 500.
module voltage_running_statistics (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [1:0]                    kind,
  input  logic [vrs_pkg::CODE_BITS-1:0] sample_code,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [vrs_pkg::CODE_BITS-1:0] current_cv,
  output logic [vrs_pkg::CODE_BITS-1:0] average_cv,
  output logic [vrs_pkg::CODE_BITS-1:0] maximum_cv,
  output logic [vrs_pkg::CODE_BITS-1:0] minimum_cv,
  output logic                          stats_valid,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [vrs_pkg::ADDR_BITS-1:0] paddr,
  input  logic [vrs_pkg::DATA_BITS-1:0] pwdata,
  output logic [vrs_pkg::DATA_BITS-1:0] prdata,
  output logic                          pready
);

  logic [vrs_pkg::CODE_BITS-1:0] reference_centivolts;
  vrs_pkg::q_port_t              push;
  vrs_pkg::q_port_t              head;
  logic                          queue_full;
  logic                          pop;

  assign pready = 1'b1;
  assign prdata = (paddr == vrs_pkg::ADDR_REFERENCE) ?
                  vrs_pkg::DATA_BITS'(reference_centivolts) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      reference_centivolts <= vrs_pkg::REF_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (paddr == vrs_pkg::ADDR_REFERENCE)) begin
      reference_centivolts <= pwdata[vrs_pkg::CODE_BITS-1:0];
    end
  end

  vrs_front u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .kind        (kind),
    .sample_code (sample_code),
    .queue_full  (queue_full),
    .push        (push)
  );

  vrs_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (queue_full),
    .pop  (pop),
    .head (head)
  );

  vrs_back u_back (
    .clk                  (clk),
    .rst                  (rst),
    .head                 (head),
    .pop                  (pop),
    .reference_centivolts (reference_centivolts),
    .result_valid         (result_valid),
    .result_stall         (result_stall),
    .current_cv           (current_cv),
    .average_cv           (average_cv),
    .maximum_cv           (maximum_cv),
    .minimum_cv           (minimum_cv),
    .stats_valid          (stats_valid)
  );

endmodule

// ===== sim/tb_voltage_running_statistics.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_voltage_running_statistics
// Self-checking bench for the running voltage statistics block.
// ----------------------------------------------------------------------------
// A driver feeds sample and key words from a queue and a monitor takes the
// results. Both sides idle at random, apart from one phase with no gaps. Each
// accepted word is run through an in-bench predictor of the mode, the running
// statistics and the centivolt scaling, and every result is compared field by
// field with the oldest prediction. The run steps through several reference
// settings, the extremes among them, and includes one long receiver hold-off
// and one pause of the sender until all results have drained.
// ----------------------------------------------------------------------------
module tb_voltage_running_statistics;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int HOLD_OFF_AT     = 250;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int DRAIN_AT        = 520;
  localparam int SETTLE_CYCLES   = 40;

  typedef struct {
    logic [1:0]                    kind;
    logic [vrs_pkg::CODE_BITS-1:0] code;
  } word_t;

  typedef struct {
    logic [vrs_pkg::CODE_BITS-1:0] current;
    logic [vrs_pkg::CODE_BITS-1:0] average;
    logic [vrs_pkg::CODE_BITS-1:0] maximum;
    logic [vrs_pkg::CODE_BITS-1:0] minimum;
    logic                          valid;
  } reading_t;

  logic                          clk;
  logic                          rst          = 1'b1;
  logic                          item_valid   = 1'b0;
  logic                          item_stall;
  logic [1:0]                    kind         = vrs_pkg::KIND_SAMPLE;
  logic [vrs_pkg::CODE_BITS-1:0] sample_code  = '0;
  logic                          result_valid;
  logic                          result_stall = 1'b0;
  logic [vrs_pkg::CODE_BITS-1:0] current_cv;
  logic [vrs_pkg::CODE_BITS-1:0] average_cv;
  logic [vrs_pkg::CODE_BITS-1:0] maximum_cv;
  logic [vrs_pkg::CODE_BITS-1:0] minimum_cv;
  logic                          stats_valid;
  logic                          psel         = 1'b0;
  logic                          penable      = 1'b0;
  logic                          pwrite       = 1'b0;
  logic [vrs_pkg::ADDR_BITS-1:0] paddr        = vrs_pkg::ADDR_REFERENCE;
  logic [vrs_pkg::DATA_BITS-1:0] pwdata       = '0;
  logic [vrs_pkg::DATA_BITS-1:0] prdata;
  logic                          pready;

  voltage_running_statistics DUT (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .kind         (kind),
    .sample_code  (sample_code),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .current_cv   (current_cv),
    .average_cv   (average_cv),
    .maximum_cv   (maximum_cv),
    .minimum_cv   (minimum_cv),
    .stats_valid  (stats_valid),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // Predictor state.
  logic [vrs_pkg::CODE_BITS-1:0]  ref_cv     = vrs_pkg::REF_RESET;
  logic                           in_hold    = 1'b0;
  logic [vrs_pkg::CODE_BITS-1:0]  low_code   = vrs_pkg::CODE_FULL;
  logic [vrs_pkg::CODE_BITS-1:0]  high_code  = '0;
  logic [vrs_pkg::COUNT_BITS-1:0] n_samples  = '0;
  logic [vrs_pkg::SUM_BITS-1:0]   code_total = '0;

  word_t    pending_words[$];
  reading_t expected_readings[$];

  bit steady   = 1'b0;
  bit draining = 1'b0;
  bit held_off = 1'b0;
  int hold_off_left  = 0;
  int words_queued   = 0;
  int words_accepted = 0;
  int results_seen   = 0;
  int mismatches     = 0;
  int phases_run     = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(2_000_000);
    $display("Timed out with %0d results outstanding.", expected_readings.size());
    $display("FAILED: results differ");
    $finish;
  end

  task automatic note_mismatch(input string what, input int got, input int want);
    mismatches++;
    $display("Mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
  endtask

  function automatic logic [vrs_pkg::CODE_BITS-1:0] to_cv(
      input logic [vrs_pkg::CODE_BITS-1:0] code);
    logic [19:0] product;
    product = 20'(code) * 20'(ref_cv);
    return vrs_pkg::CODE_BITS'(product / 20'(vrs_pkg::CODE_FULL));
  endfunction

  task automatic track_word(input logic [1:0] k, input logic [vrs_pkg::CODE_BITS-1:0] code);
    reading_t r;
    logic [vrs_pkg::SUM_BITS-1:0] mean;
    if (k == vrs_pkg::KIND_HOLD) begin
      in_hold = 1'b1;
    end else if (k == vrs_pkg::KIND_RUN) begin
      in_hold = 1'b0;
    end else if (k == vrs_pkg::KIND_SAMPLE) begin
      r.current = to_cv(code);
      if (in_hold) begin
        low_code   = vrs_pkg::CODE_FULL;
        high_code  = '0;
        n_samples  = '0;
        code_total = '0;
        r.average  = '0;
        r.maximum  = '0;
        r.minimum  = '0;
        r.valid    = 1'b0;
      end else begin
        if (n_samples == '1) begin
          n_samples  = '0;
          code_total = '0;
        end
        code_total = code_total + vrs_pkg::SUM_BITS'(code);
        n_samples  = n_samples + 1'b1;
        if (code < low_code) low_code = code;
        if (code > high_code) high_code = code;
        mean      = code_total / vrs_pkg::SUM_BITS'(n_samples);
        r.average = to_cv(mean[vrs_pkg::CODE_BITS-1:0]);
        r.maximum = to_cv(high_code);
        r.minimum = to_cv(low_code);
        r.valid   = 1'b1;
      end
      expected_readings.push_back(r);
    end
  endtask

  always @(posedge clk) begin : drive
    word_t w;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall) begin
        track_word(kind, sample_code);
        words_accepted++;
        if (words_accepted == DRAIN_AT) draining = 1'b1;
      end
      if (draining && expected_readings.size() == 0) draining = 1'b0;
      if (!item_valid || !item_stall) begin
        if (pending_words.size() > 0 && !draining && (steady || $urandom_range(99) >= 21)) begin
          w = pending_words.pop_front();
          item_valid  <= 1'b1;
          kind        <= w.kind;
          sample_code <= w.code;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    reading_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen++;
        if (expected_readings.size() == 0) begin
          note_mismatch("result with none expected, current_cv", current_cv, 0);
        end else begin
          want = expected_readings.pop_front();
          if (current_cv !== want.current) note_mismatch("current_cv", current_cv, want.current);
          if (average_cv !== want.average) note_mismatch("average_cv", average_cv, want.average);
          if (maximum_cv !== want.maximum) note_mismatch("maximum_cv", maximum_cv, want.maximum);
          if (minimum_cv !== want.minimum) note_mismatch("minimum_cv", minimum_cv, want.minimum);
          if (stats_valid !== want.valid) note_mismatch("stats_valid", stats_valid, want.valid);
        end
      end
      if (results_seen == HOLD_OFF_AT && !held_off) begin
        held_off      = 1'b1;
        hold_off_left = HOLD_OFF_CYCLES;
      end
      if (hold_off_left > 0) begin
        hold_off_left--;
        result_stall <= 1'b1;
      end else begin
        result_stall <= !steady && ($urandom_range(99) < 21);
      end
    end
  end

  task automatic queue_word(input logic [1:0] k, input logic [vrs_pkg::CODE_BITS-1:0] code);
    word_t w;
    w.kind = k;
    w.code = code;
    pending_words.push_back(w);
    words_queued++;
  endtask

  function automatic logic [vrs_pkg::CODE_BITS-1:0] pick_code(input int level);
    int r;
    int v;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return vrs_pkg::CODE_FULL;
    if (r < 45) begin
      v = level + $urandom_range(40) - 20;
      if (v < 0) v = 0;
      if (v > 1023) v = 1023;
      return vrs_pkg::CODE_BITS'(v);
    end
    return vrs_pkg::CODE_BITS'($urandom_range(1023));
  endfunction

  task automatic queue_random_words(input int n);
    int level;
    int r;
    int burst;
    level = $urandom_range(1023);
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(99);
      if (r < 8) begin
        queue_word(vrs_pkg::KIND_HOLD, vrs_pkg::CODE_BITS'($urandom));
        burst = $urandom_range(4, 1);
        for (int j = 0; j < burst; j++) queue_word(vrs_pkg::KIND_SAMPLE, pick_code(level));
        if ($urandom_range(3) != 0) queue_word(vrs_pkg::KIND_RUN, vrs_pkg::CODE_BITS'($urandom));
        i += burst + 1;
      end else if (r < 12) begin
        queue_word(vrs_pkg::KIND_RUN, vrs_pkg::CODE_BITS'($urandom));
      end else if (r < 15) begin
        queue_word(KIND_UNUSED, vrs_pkg::CODE_BITS'($urandom));
      end else begin
        queue_word(vrs_pkg::KIND_SAMPLE, pick_code(level));
      end
    end
  endtask

  task automatic set_reference(input logic [vrs_pkg::CODE_BITS-1:0] value);
    logic [vrs_pkg::DATA_BITS-1:0] data;
    data = $urandom;
    data[vrs_pkg::CODE_BITS-1:0] = value;
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= vrs_pkg::ADDR_REFERENCE;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    ref_cv = value;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[vrs_pkg::CODE_BITS-1:0] !== value)
      note_mismatch("reference readback", prdata[vrs_pkg::CODE_BITS-1:0], value);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic run_phase(input bit write_it, input logic [vrs_pkg::CODE_BITS-1:0] value,
                           input bit quiet, input int n_items);
    if (write_it) set_reference(value);
    @(posedge clk);
    steady <= quiet;
    queue_random_words(n_items);
    do @(negedge clk);
    while (!(words_accepted == words_queued && expected_readings.size() == 0));
    repeat (SETTLE_CYCLES) @(negedge clk);
    phases_run++;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset reference.
    queue_word(vrs_pkg::KIND_SAMPLE, 10'd0);
    queue_word(vrs_pkg::KIND_SAMPLE, vrs_pkg::CODE_FULL);
    queue_word(vrs_pkg::KIND_SAMPLE, 10'd512);
    queue_word(vrs_pkg::KIND_SAMPLE, 10'h155);
    queue_word(vrs_pkg::KIND_SAMPLE, 10'h2AA);
    queue_word(KIND_UNUSED, vrs_pkg::CODE_FULL);
    queue_word(vrs_pkg::KIND_HOLD, 10'h155);
    queue_word(vrs_pkg::KIND_SAMPLE, vrs_pkg::CODE_FULL);
    queue_word(vrs_pkg::KIND_SAMPLE, 10'd0);
    queue_word(vrs_pkg::KIND_HOLD, 10'h2AA);
    queue_word(vrs_pkg::KIND_SAMPLE, 10'd200);
    queue_word(vrs_pkg::KIND_RUN, vrs_pkg::CODE_FULL);
    queue_word(vrs_pkg::KIND_SAMPLE, 10'd700);
    queue_word(vrs_pkg::KIND_RUN, 10'd0);
    queue_word(vrs_pkg::KIND_SAMPLE, 10'd1);
    queue_word(KIND_UNUSED, 10'd0);
    queue_word(vrs_pkg::KIND_SAMPLE, 10'd1022);
    queue_word(vrs_pkg::KIND_HOLD, 10'd0);
    queue_word(vrs_pkg::KIND_RUN, vrs_pkg::CODE_FULL);
    queue_word(vrs_pkg::KIND_SAMPLE, 10'd300);

    run_phase(1'b0, vrs_pkg::REF_RESET, 1'b0, 100);
    run_phase(1'b1, 10'd1000, 1'b1, 150);
    run_phase(1'b1, 10'd1, 1'b0, 120);
    run_phase(1'b1, 10'd0, 1'b0, 80);
    run_phase(1'b1, vrs_pkg::CODE_FULL, 1'b0, 150);
    run_phase(1'b1, vrs_pkg::CODE_BITS'($urandom_range(1000, 1)), 1'b0, 150);
    run_phase(1'b1, vrs_pkg::CODE_BITS'($urandom), 1'b0, 180);

    mismatches += expected_readings.size();
    $display("Covered %0d words in %0d reference settings, %0d results checked,",
             words_accepted, phases_run, results_seen);
    $display("with hold and run keys, ignored words, one long hold-off and one drain.");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches.", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
